/* sv/poptrie_pkg.sv */
// ----------------------------------------------------------------------------
// poptrie_pkg
// Shared types, request codes and helpers for the poptrie IPv4 route lookup.
// ----------------------------------------------------------------------------
package poptrie_pkg;

  localparam int ADDR_BITS  = 32;
  localparam int CHUNK_BITS = 6;
  localparam int POS_W      = 6;

  localparam logic [30:0] NO_ROUTE_DIRECT = 31'h7FFF_FFFF;
  localparam logic [31:0] NO_ROUTE_LEAF   = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_LOOKUP    = 2'd0,
    CMD_WR_DIRECT = 2'd1,
    CMD_WR_NODE   = 2'd2,
    CMD_WR_LEAF   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RES_DIRECT,
    RES_LEAF,
    RES_MISS
  } res_src_t;

  typedef struct packed {
    logic [63:0] child_vec;
    logic [63:0] leaf_vec;
    logic [15:0] node_base;
    logic [15:0] leaf_base;
  } node_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic     wr;        // table write for the accepted request
    logic     dir_rd;    // read direct entry, load walk state
    logic     ld_node;   // first node index from the direct entry
    logic     node_rd;   // read node entry
    logic     step;      // descend to the child node
    logic     ld_leaf;   // latch leaf index
    logic     leaf_rd;   // read leaf entry
    logic     ld_res;    // latch result
    res_src_t res_src;
    logic     ld_out;    // move result into the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic dir_node;   // direct entry points at a node
    logic child;      // chunk bit set in the child vector
    logic walk_end;   // no address bits left after this chunk
    logic off_zero;   // masked leaf-vector popcount is zero
  } dp_sts_t;

  // 64-bit popcount: balanced adder tree over bit pairs
  function automatic logic [6:0] popcount64(input logic [63:0] v);
    logic [1:0] s2 [32];
    logic [2:0] s3 [16];
    logic [3:0] s4 [8];
    logic [4:0] s5 [4];
    logic [5:0] s6 [2];
    for (int i = 0; i < 32; i++) begin
      s2[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 16; i++) begin
      s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      s6[i] = {1'b0, s5[2*i]} + {1'b0, s5[2*i+1]};
    end
    return {1'b0, s6[0]} + {1'b0, s6[1]};
  endfunction

endpackage

/* sv/poptrie_req_if.sv */
// ----------------------------------------------------------------------------
// poptrie_req_if
// Request channel: lookup or table write, valid/ready handshake.
// ----------------------------------------------------------------------------
interface poptrie_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [17:0] table_index;
  logic [31:0] ip_addr;
  logic [63:0] word_a;
  logic [63:0] word_b;
  logic [15:0] leaf_base;
  logic [15:0] node_base;

  modport source (
    output valid, cmd, table_index, ip_addr, word_a, word_b, leaf_base, node_base,
    input  ready
  );
  modport sink (
    input  valid, cmd, table_index, ip_addr, word_a, word_b, leaf_base, node_base,
    output ready
  );
endinterface

/* sv/poptrie_rsp_if.sv */
// ----------------------------------------------------------------------------
// poptrie_rsp_if
// Result channel: forwarding port and no-route flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface poptrie_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] port;
  logic        no_route;

  modport source (output valid, port, no_route, input ready);
  modport sink   (input valid, port, no_route, output ready);
endinterface

/* sv/poptrie_dp.sv */
// ----------------------------------------------------------------------------
// poptrie_dp
// Lookup datapath: table memories, walk registers, popcount and result regs.
// ----------------------------------------------------------------------------
module poptrie_dp #(
  parameter int DIRECT_INDEX_BITS = 18,
  parameter int NODE_ADDR_BITS    = 16,
  parameter int LEAF_ADDR_BITS    = 16
) (
  input  logic                 clk,
  input  logic [1:0]           req_cmd,
  input  logic [17:0]          table_index,
  input  logic [31:0]          ip_addr,
  input  logic [63:0]          word_a,
  input  logic [63:0]          word_b,
  input  logic [15:0]          leaf_base,
  input  logic [15:0]          node_base,
  input  poptrie_pkg::dp_cmd_t cmd,
  output poptrie_pkg::dp_sts_t sts,
  output logic [31:0]          port,
  output logic                 no_route
);

  localparam int DIR_DEPTH  = 2 ** DIRECT_INDEX_BITS;
  localparam int NODE_DEPTH = 2 ** NODE_ADDR_BITS;
  localparam int LEAF_DEPTH = 2 ** LEAF_ADDR_BITS;

  logic [31:0]              dir_mem  [DIR_DEPTH];
  poptrie_pkg::node_entry_t node_mem [NODE_DEPTH];
  logic [31:0]              leaf_mem [LEAF_DEPTH];

  logic [31:0]                          dent;
  poptrie_pkg::node_entry_t             node_q;
  logic [31:0]                          leaf_q;
  logic [31:0]                          ip_sh;
  logic [poptrie_pkg::POS_W-1:0]        pos;
  logic [NODE_ADDR_BITS-1:0]            node_ptr;
  logic [LEAF_ADDR_BITS-1:0]            leaf_ptr;
  logic [31:0]                          res_port;
  logic                                 res_miss;

  logic [5:0]  chunk;
  logic        child;
  logic [63:0] below;
  logic [63:0] upto;
  logic [63:0] sel_vec;
  logic [6:0]  cnt;
  logic [16:0] child_sum;
  logic [16:0] leaf_sum;
  logic [poptrie_pkg::POS_W:0] pos_sum;

  // walk arithmetic on the current node entry
  always_comb begin
    chunk = ip_sh[31 -: poptrie_pkg::CHUNK_BITS];
    child = node_q.child_vec[chunk];
    for (int i = 0; i < 64; i++) begin
      below[i] = (6'(i) < chunk);
      upto[i]  = (6'(i) <= chunk);
    end
    sel_vec   = child ? (node_q.child_vec & below) : (node_q.leaf_vec & upto);
    cnt       = poptrie_pkg::popcount64(sel_vec);
    child_sum = {1'b0, node_q.node_base} + 17'(cnt);
    leaf_sum  = {1'b0, node_q.leaf_base} + 17'(cnt) - 17'd1;
    pos_sum   = {1'b0, pos} + 7'(poptrie_pkg::CHUNK_BITS);
  end

  assign sts.dir_node = dent[31];
  assign sts.child    = child;
  assign sts.walk_end = (pos_sum >= 7'(poptrie_pkg::ADDR_BITS));
  assign sts.off_zero = (cnt == 7'd0);

  // direct table
  always_ff @(posedge clk) begin
    if (cmd.wr && req_cmd == poptrie_pkg::CMD_WR_DIRECT) begin
      dir_mem[DIRECT_INDEX_BITS'(table_index)] <= word_a[31:0];
    end
    if (cmd.dir_rd) begin
      dent <= dir_mem[ip_addr[31 -: DIRECT_INDEX_BITS]];
    end
  end

  // node table
  always_ff @(posedge clk) begin
    if (cmd.wr && req_cmd == poptrie_pkg::CMD_WR_NODE) begin
      node_mem[NODE_ADDR_BITS'(table_index)] <= '{
        child_vec: word_a, leaf_vec: word_b, node_base: node_base, leaf_base: leaf_base
      };
    end
    if (cmd.node_rd) begin
      node_q <= node_mem[node_ptr];
    end
  end

  // leaf table
  always_ff @(posedge clk) begin
    if (cmd.wr && req_cmd == poptrie_pkg::CMD_WR_LEAF) begin
      leaf_mem[LEAF_ADDR_BITS'(table_index)] <= word_a[31:0];
    end
    if (cmd.leaf_rd) begin
      leaf_q <= leaf_mem[leaf_ptr];
    end
  end

  // walk state
  always_ff @(posedge clk) begin
    if (cmd.dir_rd) begin
      ip_sh <= ip_addr << DIRECT_INDEX_BITS;
      pos   <= poptrie_pkg::POS_W'(DIRECT_INDEX_BITS);
    end else if (cmd.step) begin
      ip_sh <= ip_sh << poptrie_pkg::CHUNK_BITS;
      pos   <= pos_sum[poptrie_pkg::POS_W-1:0];
    end
    if (cmd.ld_node) begin
      node_ptr <= NODE_ADDR_BITS'(dent[30:0]);
    end else if (cmd.step) begin
      node_ptr <= NODE_ADDR_BITS'(child_sum);
    end
    if (cmd.ld_leaf) begin
      leaf_ptr <= LEAF_ADDR_BITS'(leaf_sum);
    end
  end

  // result and output registers
  always_ff @(posedge clk) begin
    if (cmd.ld_res) begin
      case (cmd.res_src)
        poptrie_pkg::RES_DIRECT: begin
          res_port <= {1'b0, dent[30:0]};
          res_miss <= (dent[30:0] == poptrie_pkg::NO_ROUTE_DIRECT);
        end
        poptrie_pkg::RES_LEAF: begin
          res_port <= leaf_q;
          res_miss <= (leaf_q == poptrie_pkg::NO_ROUTE_LEAF);
        end
        default: begin
          res_port <= '0;
          res_miss <= 1'b1;
        end
      endcase
    end
    if (cmd.ld_out) begin
      port     <= res_miss ? 32'd0 : res_port;
      no_route <= res_miss;
    end
  end

endmodule

/* sv/poptrie_ctrl.sv */
// ----------------------------------------------------------------------------
// poptrie_ctrl
// Lookup sequencer: direct read, node walk, leaf read, result hand-off.
// ----------------------------------------------------------------------------
module poptrie_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic [1:0]           req_cmd,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output poptrie_pkg::dp_cmd_t cmd,
  input  poptrie_pkg::dp_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIRECT,
    S_NODE_RD,
    S_NODE,
    S_LEAF_RD,
    S_LEAF,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.res_src = poptrie_pkg::RES_MISS;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req_cmd == poptrie_pkg::CMD_LOOKUP) begin
            cmd.dir_rd = 1'b1;
            state_next = S_DIRECT;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_DIRECT: begin
        if (sts.dir_node) begin
          cmd.ld_node = 1'b1;
          state_next  = S_NODE_RD;
        end else begin
          cmd.ld_res  = 1'b1;
          cmd.res_src = poptrie_pkg::RES_DIRECT;
          state_next  = S_RESULT;
        end
      end
      S_NODE_RD: begin
        cmd.node_rd = 1'b1;
        state_next  = S_NODE;
      end
      S_NODE: begin
        if (sts.child) begin
          if (sts.walk_end) begin
            cmd.ld_res = 1'b1;
            state_next = S_RESULT;
          end else begin
            cmd.step   = 1'b1;
            state_next = S_NODE_RD;
          end
        end else if (sts.off_zero) begin
          cmd.ld_res = 1'b1;
          state_next = S_RESULT;
        end else begin
          cmd.ld_leaf = 1'b1;
          state_next  = S_LEAF_RD;
        end
      end
      S_LEAF_RD: begin
        cmd.leaf_rd = 1'b1;
        state_next  = S_LEAF;
      end
      S_LEAF: begin
        cmd.ld_res  = 1'b1;
        cmd.res_src = poptrie_pkg::RES_LEAF;
        state_next  = S_RESULT;
      end
      S_RESULT: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.ld_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign rsp_valid_next = cmd.ld_out | (rsp_valid & ~rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

/* sv/poptrie_ipv4_route_lookup.sv */
// ----------------------------------------------------------------------------
// poptrie_ipv4_route_lookup
// Lookup: a direct leaf answers from the direct read; each node adds a node read,
// and a leaf-table hit adds a leaf read. One lookup at a time; the next is taken
// once the result enters the output register. Writes: 1 per cycle while idle.
// Lookup time is set by the dependent memory reads of the walk.
// Reset clears the sequencer and rsp.valid; tables are not cleared.
// ----------------------------------------------------------------------------
module poptrie_ipv4_route_lookup #(
  parameter int DIRECT_INDEX_BITS = 18,
  parameter int NODE_ADDR_BITS    = 16,
  parameter int LEAF_ADDR_BITS    = 16
) (
  input logic          clk,
  input logic          rst,
  poptrie_req_if.sink  req,
  poptrie_rsp_if.source rsp
);

  // Requests: lookup, or a write to the direct, node or leaf table.
  // A write is done at the accept edge and the block stays ready.
  // A lookup runs the sequencer:
  //   direct read -> (node read, popcount step)* -> optional leaf read
  // Each node step takes the next 6 address bits as the chunk; the child
  // bit picks descend or leaf, and the popcount of the masked vector gives
  // the child or leaf offset. The output register lets a finished result
  // wait for the sink while the sequencer returns to idle.

  poptrie_pkg::dp_cmd_t cmd;
  poptrie_pkg::dp_sts_t sts;

  poptrie_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  poptrie_dp #(
    .DIRECT_INDEX_BITS (DIRECT_INDEX_BITS),
    .NODE_ADDR_BITS    (NODE_ADDR_BITS),
    .LEAF_ADDR_BITS    (LEAF_ADDR_BITS)
  ) u_dp (
    .clk         (clk),
    .req_cmd     (req.cmd),
    .table_index (req.table_index),
    .ip_addr     (req.ip_addr),
    .word_a      (req.word_a),
    .word_b      (req.word_b),
    .leaf_base   (req.leaf_base),
    .node_base   (req.node_base),
    .cmd         (cmd),
    .sts         (sts),
    .port        (rsp.port),
    .no_route    (rsp.no_route)
  );

`ifndef ASSERT_OFF
  // a miss never carries a port
  a_miss_port_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.no_route |-> rsp.port == 32'd0)
    else $error("no-route result with non-zero port");

  // table writes do not occupy the sequencer
  a_write_no_stall: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.cmd != poptrie_pkg::CMD_LOOKUP |=> req.ready)
    else $error("ready dropped after a table write");

  // a lookup holds off further requests until its result enters the output register
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.cmd == poptrie_pkg::CMD_LOOKUP |=> !req.ready)
    else $error("request accepted during a lookup");

  // a result is only loaded while the sink slot is free or draining
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.ld_out |-> !rsp.valid || rsp.ready)
    else $error("output register overwritten");
`endif

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the poptrie IPv4 route lookup. Loads the direct,
// node and leaf tables by request, fires lookups whose walks only touch
// entries already loaded, and checks every result against a local walk of
// the same tables under random idling on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int          DIR_BITS    = 18;
  localparam int          NODE_BITS   = 16;
  localparam int          LEAF_BITS   = 16;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          SETTLE      = 20;
  localparam logic [15:0] HI_SLOT     = 16'hFFE0; // upper table window start

  typedef struct {
    logic [31:0] port;
    logic        no_route;
  } route_t;

  logic clk;
  logic rst;

  poptrie_req_if req ();
  poptrie_rsp_if rsp ();

  poptrie_ipv4_route_lookup #(
    .DIRECT_INDEX_BITS(DIR_BITS),
    .NODE_ADDR_BITS   (NODE_BITS),
    .LEAF_ADDR_BITS   (LEAF_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // local copy of the tables; only written entries exist
  logic [31:0] direct_mem    [int unsigned];
  logic [63:0] child_vec_mem [int unsigned];
  logic [63:0] leaf_vec_mem  [int unsigned];
  logic [15:0] node_base_mem [int unsigned];
  logic [15:0] leaf_base_mem [int unsigned];
  logic [31:0] leaf_mem      [int unsigned];
  logic [17:0] direct_keys [$];

  route_t      expected_routes [$];
  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  int unsigned fault_count;
  int unsigned cycle_count;
  int unsigned lookups_sent;
  int unsigned writes_sent;
  int unsigned misses_seen;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_routes.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  function automatic void log_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endfunction

  // Walk of the tables for one address. Returns 0 when the walk would read an
  // entry never loaded; such a request is not sent.
  function automatic bit resolve_route(input logic [31:0] ip, output route_t r);
    logic [31:0] dent;
    logic [31:0] shifted;
    logic [15:0] node;
    logic [15:0] li;
    logic [63:0] cv;
    logic [5:0]  chunk;
    int unsigned off;
    r.port     = '0;
    r.no_route = 1'b1;
    if (!direct_mem.exists(ip[31:32-DIR_BITS])) return 1'b0;
    dent = direct_mem[ip[31:32-DIR_BITS]];
    if (!dent[31]) begin
      r.no_route = (dent[30:0] == poptrie_pkg::NO_ROUTE_DIRECT);
      r.port     = r.no_route ? 32'd0 : {1'b0, dent[30:0]};
      return 1'b1;
    end
    node = dent[15:0];
    for (int pos = DIR_BITS; pos < 32; pos += poptrie_pkg::CHUNK_BITS) begin
      if (!child_vec_mem.exists(node)) return 1'b0;
      shifted = ip << pos;
      chunk   = shifted[31:26];          // short last chunk comes out zero-filled
      cv      = child_vec_mem[node];
      if (cv[chunk]) begin
        node = node_base_mem[node] + 16'($countones(cv & ((64'd1 << chunk) - 64'd1)));
      end else begin
        off = $countones(leaf_vec_mem[node] & ({64{1'b1}} >> (63 - chunk)));
        if (off == 0) return 1'b1;       // no leaf run starts at or below the chunk
        li = leaf_base_mem[node] + 16'(off - 1);
        if (!leaf_mem.exists(li)) return 1'b0;
        r.no_route = (leaf_mem[li] == poptrie_pkg::NO_ROUTE_LEAF);
        r.port     = r.no_route ? 32'd0 : leaf_mem[li];
        return 1'b1;
      end
    end
    return 1'b1;                         // ran out of address while still at nodes
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // vectors of varied density so walks both descend and stop early
  function automatic logic [63:0] shaped_vec();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return rand64() & rand64();
      4:       return rand64() | rand64();
      default: return rand64();
    endcase
  endfunction

  // node and leaf tables are loaded in full at 0..63 and 0xFFE0..0xFFFF
  function automatic logic [15:0] window_slot();
    return $urandom_range(0, 1) ? 16'($urandom_range(0, 63))
                                : 16'($urandom_range(HI_SLOT, 16'hFFFF));
  endfunction

  // base whose run of cnt entries stays inside the loaded windows, wrap included
  function automatic logic [15:0] safe_base(input int unsigned cnt);
    if (cnt == 0) return 16'($urandom);
    return $urandom_range(0, 1) ? 16'($urandom_range(0, 64 - cnt))
                                : 16'($urandom_range(HI_SLOT, 16'hFFFF));
  endfunction

  function automatic logic [31:0] pack_ip(input logic [17:0] d, input logic [5:0] c1,
                                          input logic [5:0] c2, input logic [1:0] c3);
    return {d, c1, c2, c3};
  endfunction

  always @(posedge clk) begin
    route_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (rsp.no_route) misses_seen++;
      if (expected_routes.size() == 0) begin
        log_fault($sformatf("unexpected result: port %h no_route %b",
                            rsp.port, rsp.no_route));
      end else begin
        want = expected_routes.pop_front();
        if (rsp.port !== want.port || rsp.no_route !== want.no_route) begin
          log_fault($sformatf("mismatch: port exp %h got %h, no_route exp %b got %b",
                              want.port, rsp.port, want.no_route, rsp.no_route));
        end
      end
    end
  end

  // one request through the channel; the tables are updated when it is taken
  task automatic issue_request(input poptrie_pkg::op_t op, input logic [17:0] tidx,
                               input logic [31:0] ip, input logic [63:0] wa,
                               input logic [63:0] wb, input logic [15:0] lb,
                               input logic [15:0] nb);
    route_t r;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.cmd         <= op;
    req.table_index <= tidx;
    req.ip_addr     <= ip;
    req.word_a      <= wa;
    req.word_b      <= wb;
    req.leaf_base   <= lb;
    req.node_base   <= nb;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    case (op)
      poptrie_pkg::CMD_WR_DIRECT: begin
        if (!direct_mem.exists(tidx)) direct_keys.push_back(tidx);
        direct_mem[tidx] = wa[31:0];
        writes_sent++;
      end
      poptrie_pkg::CMD_WR_NODE: begin
        child_vec_mem[tidx[15:0]] = wa;
        leaf_vec_mem[tidx[15:0]]  = wb;
        node_base_mem[tidx[15:0]] = nb;
        leaf_base_mem[tidx[15:0]] = lb;
        writes_sent++;
      end
      poptrie_pkg::CMD_WR_LEAF: begin
        leaf_mem[tidx[15:0]] = wa[31:0];
        writes_sent++;
      end
      default: begin
        void'(resolve_route(ip, r));
        expected_routes.push_back(r);
        lookups_sent++;
      end
    endcase
  endtask

  // lookup only if its walk stays on loaded entries
  task automatic try_lookup(input logic [31:0] ip, output bit sent);
    route_t r;
    sent = resolve_route(ip, r);
    if (sent) issue_request(poptrie_pkg::CMD_LOOKUP, 18'($urandom), ip, rand64(), rand64(),
                            16'($urandom), 16'($urandom));
  endtask

  task automatic write_random_direct();
    logic [31:0] ent;
    case ($urandom_range(0, 9))
      0:       ent = {1'b0, poptrie_pkg::NO_ROUTE_DIRECT};
      1, 2, 3: ent = {1'b0, 31'($urandom)};
      default: ent = {1'b1, 15'($urandom), window_slot()};
    endcase
    issue_request(poptrie_pkg::CMD_WR_DIRECT, 18'($urandom), $urandom, {$urandom, ent},
                  rand64(), 16'($urandom), 16'($urandom));
  endtask

  task automatic write_random_node(input logic [15:0] slot);
    logic [63:0] cv;
    logic [63:0] lv;
    cv = shaped_vec();
    lv = shaped_vec();
    issue_request(poptrie_pkg::CMD_WR_NODE, {2'($urandom), slot}, $urandom, cv, lv,
                  safe_base($countones(lv)), safe_base($countones(cv)));
  endtask

  task automatic write_random_leaf(input logic [15:0] slot);
    logic [31:0] port;
    case ($urandom_range(0, 7))
      0:       port = poptrie_pkg::NO_ROUTE_LEAF;
      1:       port = '0;
      default: port = $urandom;
    endcase
    issue_request(poptrie_pkg::CMD_WR_LEAF, {2'($urandom), slot}, $urandom,
                  {$urandom, port}, rand64(), 16'($urandom), 16'($urandom));
  endtask

  // sender holds off until every lookup in flight has answered
  task automatic hold_until_drained();
    req.valid <= 1'b0;
    do @(posedge clk); while (expected_routes.size() != 0);
  endtask

  // Hand-built trie: node 5 at the top, node 0xFFFF chaining to itself, node 0
  // with leaves only. Covers both no-route markers, a zero leaf offset, chunk
  // 63, the short last chunk, base wrap in node and leaf indices, a wrapped
  // node index in a direct entry and a walk that runs off the address.
  task automatic test_directed_cases();
    bit sent;
    issue_request(poptrie_pkg::CMD_WR_LEAF, 18'h00000, 32'h0,
                  {32'hFFFF_FFFF, 32'h1234_5678}, '1, 16'hFFFF, 16'hFFFF);
    issue_request(poptrie_pkg::CMD_WR_LEAF, 18'h00001, '1,
                  {32'h0, poptrie_pkg::NO_ROUTE_LEAF}, '0, '0, '0);
    issue_request(poptrie_pkg::CMD_WR_LEAF, 18'h3FFFF, $urandom, 64'h0, rand64(),
                  16'($urandom), 16'($urandom));
    issue_request(poptrie_pkg::CMD_WR_NODE, 18'h10005, $urandom, 64'hC,
                  64'h8000_0000_0000_0002, 16'h0000, 16'hFFFF);
    issue_request(poptrie_pkg::CMD_WR_NODE, 18'h0FFFF, $urandom, '1, rand64(),
                  16'($urandom), 16'hFFFF);
    issue_request(poptrie_pkg::CMD_WR_NODE, 18'h20000, $urandom, '0, 64'h2_0003,
                  16'hFFFF, 16'($urandom));
    issue_request(poptrie_pkg::CMD_WR_DIRECT, 18'h00000, $urandom, {$urandom, 32'h8000_0005},
                  rand64(), 16'($urandom), 16'($urandom));
    issue_request(poptrie_pkg::CMD_WR_DIRECT, 18'h3FFFF, $urandom, {$urandom, 32'h7FFF_FFFF},
                  rand64(), 16'($urandom), 16'($urandom));
    issue_request(poptrie_pkg::CMD_WR_DIRECT, 18'h00001, $urandom,
                  {32'hFFFF_FFFF, 32'h7FFF_FFFE}, rand64(), 16'($urandom), 16'($urandom));
    issue_request(poptrie_pkg::CMD_WR_DIRECT, 18'h00002, $urandom, 64'h0, rand64(),
                  16'($urandom), 16'($urandom));
    issue_request(poptrie_pkg::CMD_WR_DIRECT, 18'h00003, $urandom, {$urandom, 32'hFFFF_0005},
                  rand64(), 16'($urandom), 16'($urandom));
    issue_request(poptrie_pkg::CMD_WR_DIRECT, 18'h00004, $urandom, {$urandom, 32'h8000_FFFF},
                  rand64(), 16'($urandom), 16'($urandom));

    try_lookup(32'h0000_0000, sent);                              // zero leaf offset
    try_lookup(32'hFFFF_FFFF, sent);                              // direct marker
    try_lookup(pack_ip(18'd1, 6'($urandom), 6'($urandom), 2'($urandom)), sent);
    try_lookup(pack_ip(18'd2, 6'($urandom), 6'($urandom), 2'($urandom)), sent);
    try_lookup(pack_ip(18'd0, 6'd1, 6'($urandom), 2'($urandom)), sent);
    try_lookup(pack_ip(18'd0, 6'd62, 6'($urandom), 2'($urandom)), sent);
    try_lookup(pack_ip(18'd0, 6'd63, 6'($urandom), 2'($urandom)), sent); // leaf marker
    try_lookup(pack_ip(18'd3, 6'd1, 6'($urandom), 2'($urandom)), sent);
    try_lookup(pack_ip(18'd0, 6'd3, 6'd0, 2'($urandom)), sent);   // node wrap to 0
    try_lookup(pack_ip(18'd0, 6'd3, 6'd1, 2'($urandom)), sent);   // leaf wrap to 0
    try_lookup(pack_ip(18'd4, 6'd0, 6'd0, 2'd0), sent);           // past bit 32
    try_lookup(pack_ip(18'd0, 6'd2, 6'd1, 2'd1), sent);           // short chunk 16
    try_lookup(pack_ip(18'd0, 6'd2, 6'd1, 2'd2), sent);           // short chunk 32
  endtask

  // fill both windows of the node and leaf tables, then a spread of direct entries
  task automatic test_table_load();
    for (int i = 0; i < 64; i++) begin
      write_random_leaf(16'(i));
      write_random_node(16'(i));
      if (i < 32) begin
        write_random_leaf(HI_SLOT + 16'(i));
        write_random_node(HI_SLOT + 16'(i));
      end
    end
    repeat (32) write_random_direct();
  endtask

  // mostly lookups through loaded entries, some rewrites and some stray addresses
  task automatic test_random_traffic(input int unsigned count);
    int unsigned done;
    int unsigned pick;
    logic [31:0] ip;
    bit          sent;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        if ($urandom_range(0, 9) == 0) ip = $urandom;
        else ip = {direct_keys[$urandom_range(0, direct_keys.size() - 1)], 14'($urandom)};
        try_lookup(ip, sent);
        if (sent) done++;
      end else begin
        if (pick < 86)      write_random_direct();
        else if (pick < 93) write_random_node(window_slot());
        else                write_random_leaf(window_slot());
        done++;
      end
      if (done == count / 2) begin
        hold_until_drained();
        done++;
        // the hold counts as a slot so it happens once
      end
    end
  endtask

  initial begin
    rst               = 1'b1;
    req.valid         = 1'b0;
    req.cmd           = poptrie_pkg::CMD_LOOKUP;
    req.table_index   = '0;
    req.ip_addr       = '0;
    req.word_a        = '0;
    req.word_b        = '0;
    req.leaf_base     = '0;
    req.node_base     = '0;
    rsp.ready         = 1'b0;
    cycle_count       = 0;
    fault_count       = 0;
    lookups_sent      = 0;
    writes_sent       = 0;
    misses_seen       = 0;
    sender_idle_pct   = 29;
    receiver_idle_pct = 70;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_table_load();
    test_random_traffic(220);
    hold_until_drained();

    sender_idle_pct   = 70;
    receiver_idle_pct = 29;
    test_random_traffic(220);
    hold_until_drained();

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    test_random_traffic(220);

    hold_until_drained();
    repeat (SETTLE) @(posedge clk);
    if (expected_routes.size() != 0) begin
      log_fault($sformatf("%0d results never arrived", expected_routes.size()));
    end
    $display("run: %0d lookups (%0d no-route), %0d table writes, %0d cycles",
             lookups_sent, misses_seen, writes_sent, cycle_count);
    $display("idle mixes 29/70, 70/29 and none; %0d mismatches", fault_count);
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
